FILE: hw/rtl/tsl_pkg.sv
package tsl_pkg;

    localparam int MAX_LEVELS      = 16;
    localparam int COORD_FRAC_BITS = 12;
    localparam int COORD_W         = 24;
    localparam int WEIGHT_W        = 17;
    localparam int WEIGHT_SHIFT    = 16;
    localparam int PATH_W          = 2 * MAX_LEVELS;
    localparam int LEVEL_W         = 5;
    localparam int DIFF_W          = COORD_W + 1;
    localparam int PROD_W          = 2 * DIFF_W;
    localparam int CROSS_W         = PROD_W + 1;
    localparam int NUM_TESTS       = 3;
    localparam int MAP_PROD_W      = COORD_W + WEIGHT_W + 1;
    localparam int MAP_SUM_W       = MAP_PROD_W + 2;
    localparam int ADDR_W          = 5;
    localparam int DATA_W          = 32;
    localparam int IN_DATA_W       = 56;
    localparam int OUT_DATA_W      = PATH_W + 8 * COORD_W;

    localparam logic [2:0] REG_ROOT_A_X = 3'd0;
    localparam logic [2:0] REG_ROOT_A_Y = 3'd1;
    localparam logic [2:0] REG_ROOT_B_X = 3'd2;
    localparam logic [2:0] REG_ROOT_B_Y = 3'd3;
    localparam logic [2:0] REG_ROOT_C_X = 3'd4;
    localparam logic [2:0] REG_ROOT_C_Y = 3'd5;
    localparam logic [2:0] REG_LEVELS   = 3'd6;

    localparam logic [1:0] CHILD_A   = 2'd0;
    localparam logic [1:0] CHILD_B   = 2'd1;
    localparam logic [1:0] CHILD_C   = 2'd2;
    localparam logic [1:0] CHILD_MID = 2'd3;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
    } vec_t;

    typedef struct packed {
        vec_t a;
        vec_t b;
        vec_t c;
    } vtx_t;

    typedef struct packed {
        vtx_t              vtx;
        vec_t              p;
        logic [PATH_W-1:0] path;
    } loc_item_t;

endpackage

FILE: hw/rtl/tsl_map.sv
module tsl_map (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [tsl_pkg::WEIGHT_W-1:0]      bary_u,
    input  logic [tsl_pkg::WEIGHT_W-1:0]      bary_v,
    input  logic [tsl_pkg::WEIGHT_W-1:0]      bary_w,
    input  tsl_pkg::vtx_t                     root,
    output logic                              out_valid,
    input  logic                              out_ready,
    output tsl_pkg::loc_item_t                out_item
);

    logic signed [tsl_pkg::MAP_PROD_W-1:0] prod_reg  [6];
    logic signed [tsl_pkg::MAP_PROD_W-1:0] prod_next [6];
    logic                                  s1_valid_reg;
    logic                                  s2_valid_reg;
    tsl_pkg::loc_item_t                    item_reg;
    tsl_pkg::loc_item_t                    item_next;
    logic                                  s1_ready;
    logic                                  s2_ready;
    logic signed [tsl_pkg::WEIGHT_W:0]     wu;
    logic signed [tsl_pkg::WEIGHT_W:0]     wv;
    logic signed [tsl_pkg::WEIGHT_W:0]     ww;
    logic signed [tsl_pkg::MAP_SUM_W-1:0]  sum_x;
    logic signed [tsl_pkg::MAP_SUM_W-1:0]  sum_y;
    logic signed [tsl_pkg::MAP_SUM_W-1:0]  sh_x;
    logic signed [tsl_pkg::MAP_SUM_W-1:0]  sh_y;

    function automatic tsl_pkg::coord_t sat_coord(
        input logic signed [tsl_pkg::MAP_SUM_W-1:0] v
    );
        logic [tsl_pkg::MAP_SUM_W-tsl_pkg::COORD_W:0] top;
        tsl_pkg::coord_t                               res;
        top = v[tsl_pkg::MAP_SUM_W-1:tsl_pkg::COORD_W-1];
        if ((&top) || !(|top)) begin
            res = v[tsl_pkg::COORD_W-1:0];
        end else if (v[tsl_pkg::MAP_SUM_W-1]) begin
            res = {1'b1, {(tsl_pkg::COORD_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(tsl_pkg::COORD_W-1){1'b1}}};
        end
        return res;
    endfunction

    assign s2_ready  = !s2_valid_reg || out_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign in_ready  = s1_ready;
    assign out_valid = s2_valid_reg;
    assign out_item  = item_reg;

    // weighted vertex products
    always_comb begin
        wu = $signed({1'b0, bary_u});
        wv = $signed({1'b0, bary_v});
        ww = $signed({1'b0, bary_w});
        prod_next[0] = $signed(root.a.x) * wu;
        prod_next[1] = $signed(root.b.x) * wv;
        prod_next[2] = $signed(root.c.x) * ww;
        prod_next[3] = $signed(root.a.y) * wu;
        prod_next[4] = $signed(root.b.y) * wv;
        prod_next[5] = $signed(root.c.y) * ww;
    end

    // sum, floor shift, saturate
    always_comb begin
        sum_x = tsl_pkg::MAP_SUM_W'(prod_reg[0]) + tsl_pkg::MAP_SUM_W'(prod_reg[1])
              + tsl_pkg::MAP_SUM_W'(prod_reg[2]);
        sum_y = tsl_pkg::MAP_SUM_W'(prod_reg[3]) + tsl_pkg::MAP_SUM_W'(prod_reg[4])
              + tsl_pkg::MAP_SUM_W'(prod_reg[5]);
        sh_x  = sum_x >>> tsl_pkg::WEIGHT_SHIFT;
        sh_y  = sum_y >>> tsl_pkg::WEIGHT_SHIFT;
        item_next.vtx  = root;
        item_next.p.x  = sat_coord(sh_x);
        item_next.p.y  = sat_coord(sh_y);
        item_next.path = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            if (s1_ready) begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready) begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_ready && in_valid) begin
            for (int i = 0; i < 6; i++) begin
                prod_reg[i] <= prod_next[i];
            end
        end
        if (s2_ready && s1_valid_reg) begin
            item_reg <= item_next;
        end
    end

endmodule

FILE: hw/rtl/tsl_cell.sv
module tsl_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               lvl_active,
    input  logic               in_valid,
    output logic               in_ready,
    input  tsl_pkg::loc_item_t in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output tsl_pkg::loc_item_t out_item
);

    localparam int NP = 4 * tsl_pkg::NUM_TESTS;

    logic                              s1_valid_reg;
    logic                              s2_valid_reg;
    logic                              s1_ready;
    logic                              s2_ready;
    tsl_pkg::loc_item_t                s1_item_reg;
    tsl_pkg::vtx_t                     s1_mid_reg;
    tsl_pkg::vtx_t                     mid_next;
    logic signed [tsl_pkg::PROD_W-1:0] prod_reg  [NP];
    logic signed [tsl_pkg::PROD_W-1:0] prod_next [NP];
    tsl_pkg::vec_t                     org [tsl_pkg::NUM_TESTS];
    tsl_pkg::vec_t                     dst [tsl_pkg::NUM_TESTS];
    tsl_pkg::vec_t                     rv  [tsl_pkg::NUM_TESTS];
    logic [tsl_pkg::NUM_TESTS-1:0]     hit;
    logic [1:0]                        child;
    tsl_pkg::loc_item_t                item_reg;
    tsl_pkg::loc_item_t                item_next;

    function automatic tsl_pkg::coord_t mid_coord(
        input tsl_pkg::coord_t m,
        input tsl_pkg::coord_t n
    );
        logic signed [tsl_pkg::COORD_W:0] s;
        s = $signed({m[tsl_pkg::COORD_W-1], m}) + $signed({n[tsl_pkg::COORD_W-1], n});
        return s[tsl_pkg::COORD_W:1];
    endfunction

    function automatic logic signed [tsl_pkg::DIFF_W-1:0] sub_coord(
        input tsl_pkg::coord_t m,
        input tsl_pkg::coord_t n
    );
        return $signed({m[tsl_pkg::COORD_W-1], m}) - $signed({n[tsl_pkg::COORD_W-1], n});
    endfunction

    assign s2_ready  = !s2_valid_reg || out_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign in_ready  = s1_ready;
    assign out_valid = s2_valid_reg;
    assign out_item  = item_reg;

    // midpoints and cross-product terms
    always_comb begin
        mid_next.a.x = mid_coord(in_item.vtx.b.x, in_item.vtx.c.x);
        mid_next.a.y = mid_coord(in_item.vtx.b.y, in_item.vtx.c.y);
        mid_next.b.x = mid_coord(in_item.vtx.a.x, in_item.vtx.c.x);
        mid_next.b.y = mid_coord(in_item.vtx.a.y, in_item.vtx.c.y);
        mid_next.c.x = mid_coord(in_item.vtx.a.x, in_item.vtx.b.x);
        mid_next.c.y = mid_coord(in_item.vtx.a.y, in_item.vtx.b.y);
        // line mc-mb against a, line mc-ma against b, line mb-ma against c
        org[0] = mid_next.c;  dst[0] = mid_next.b;  rv[0] = in_item.vtx.a;
        org[1] = mid_next.c;  dst[1] = mid_next.a;  rv[1] = in_item.vtx.b;
        org[2] = mid_next.b;  dst[2] = mid_next.a;  rv[2] = in_item.vtx.c;
        for (int t = 0; t < tsl_pkg::NUM_TESTS; t++) begin
            prod_next[4*t]   = sub_coord(in_item.p.x, org[t].x)
                             * sub_coord(dst[t].y, org[t].y);
            prod_next[4*t+1] = sub_coord(in_item.p.y, org[t].y)
                             * sub_coord(dst[t].x, org[t].x);
            prod_next[4*t+2] = sub_coord(rv[t].x, org[t].x)
                             * sub_coord(dst[t].y, org[t].y);
            prod_next[4*t+3] = sub_coord(rv[t].y, org[t].y)
                             * sub_coord(dst[t].x, org[t].x);
        end
    end

    // strict same-side tests and child pick
    always_comb begin
        logic signed [tsl_pkg::CROSS_W-1:0] c1;
        logic signed [tsl_pkg::CROSS_W-1:0] c2;
        logic                               pos1;
        logic                               pos2;
        for (int t = 0; t < tsl_pkg::NUM_TESTS; t++) begin
            c1 = tsl_pkg::CROSS_W'(prod_reg[4*t]) - tsl_pkg::CROSS_W'(prod_reg[4*t+1]);
            c2 = tsl_pkg::CROSS_W'(prod_reg[4*t+2]) - tsl_pkg::CROSS_W'(prod_reg[4*t+3]);
            pos1 = !c1[tsl_pkg::CROSS_W-1] && (|c1);
            pos2 = !c2[tsl_pkg::CROSS_W-1] && (|c2);
            hit[t] = (pos1 && pos2) || (c1[tsl_pkg::CROSS_W-1] && c2[tsl_pkg::CROSS_W-1]);
        end
        if (hit[0]) begin
            child = tsl_pkg::CHILD_A;
        end else if (hit[1]) begin
            child = tsl_pkg::CHILD_B;
        end else if (hit[2]) begin
            child = tsl_pkg::CHILD_C;
        end else begin
            child = tsl_pkg::CHILD_MID;
        end
        item_next = s1_item_reg;
        if (lvl_active) begin
            item_next.path = {s1_item_reg.path[tsl_pkg::PATH_W-3:0], child};
            case (child)
                tsl_pkg::CHILD_A: begin
                    item_next.vtx.b = s1_mid_reg.b;
                    item_next.vtx.c = s1_mid_reg.c;
                end
                tsl_pkg::CHILD_B: begin
                    item_next.vtx.a = s1_mid_reg.c;
                    item_next.vtx.c = s1_mid_reg.a;
                end
                tsl_pkg::CHILD_C: begin
                    item_next.vtx.a = s1_mid_reg.b;
                    item_next.vtx.b = s1_mid_reg.a;
                end
                default: begin
                    item_next.vtx.a = s1_mid_reg.b;
                    item_next.vtx.b = s1_mid_reg.a;
                    item_next.vtx.c = s1_mid_reg.c;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            if (s1_ready) begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready) begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_ready && in_valid) begin
            s1_item_reg <= in_item;
            s1_mid_reg  <= mid_next;
            for (int i = 0; i < NP; i++) begin
                prod_reg[i] <= prod_next[i];
            end
        end
        if (s2_ready && s1_valid_reg) begin
            item_reg <= item_next;
        end
    end

endmodule

FILE: hw/rtl/triangle_subdivision_locator_top.sv
// pipeline: 2 mapping stages, then 2 per level cell, between request accept and result valid
// throughput: one request per cycle unless m_tready stalls the output; the chain of 16 two-stage
// level cells takes a new request each cycle, and any empty stage keeps accepting while a result waits
// inactive level cells beyond the configured level count pass the request through unchanged
// reset: synchronous active-low aresetn empties the pipeline and restores the register defaults
module triangle_subdivision_locator_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [tsl_pkg::ADDR_W-1:0]         paddr,
    input  logic [tsl_pkg::DATA_W-1:0]         pwdata,
    output logic [tsl_pkg::DATA_W-1:0]         prdata,
    output logic                               pready,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // bary_u, bary_v, bary_w, zero fill
    input  logic [tsl_pkg::IN_DATA_W-1:0]      s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // cell_path, point_x, point_y, leaf_a_x, leaf_a_y, leaf_b_x, leaf_b_y, leaf_c_x, leaf_c_y
    output logic [tsl_pkg::OUT_DATA_W-1:0]     m_tdata
);

    localparam int NC = tsl_pkg::MAX_LEVELS;
    localparam int WW = tsl_pkg::WEIGHT_W;
    localparam int CW = tsl_pkg::COORD_W;

    tsl_pkg::vtx_t               root_reg;
    logic [tsl_pkg::LEVEL_W-1:0] levels_reg;
    logic [tsl_pkg::LEVEL_W-1:0] lv_eff;
    logic                        cfg_wr;
    logic [2:0]                  cfg_idx;
    logic [NC-1:0]               lvl_active;
    logic                        chain_valid [NC+1];
    logic                        chain_ready [NC+1];
    tsl_pkg::loc_item_t          chain_item  [NC+1];
    tsl_pkg::loc_item_t          res;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            root_reg.a.x <= '0;
            root_reg.a.y <= '0;
            root_reg.b.x <= CW'(1 << tsl_pkg::COORD_FRAC_BITS);
            root_reg.b.y <= '0;
            root_reg.c.x <= '0;
            root_reg.c.y <= CW'(1 << tsl_pkg::COORD_FRAC_BITS);
            levels_reg   <= tsl_pkg::LEVEL_W'(8);
        end else if (cfg_wr) begin
            case (cfg_idx)
                tsl_pkg::REG_ROOT_A_X: root_reg.a.x <= pwdata[CW-1:0];
                tsl_pkg::REG_ROOT_A_Y: root_reg.a.y <= pwdata[CW-1:0];
                tsl_pkg::REG_ROOT_B_X: root_reg.b.x <= pwdata[CW-1:0];
                tsl_pkg::REG_ROOT_B_Y: root_reg.b.y <= pwdata[CW-1:0];
                tsl_pkg::REG_ROOT_C_X: root_reg.c.x <= pwdata[CW-1:0];
                tsl_pkg::REG_ROOT_C_Y: root_reg.c.y <= pwdata[CW-1:0];
                tsl_pkg::REG_LEVELS:   levels_reg   <= pwdata[tsl_pkg::LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            tsl_pkg::REG_ROOT_A_X: prdata = tsl_pkg::DATA_W'(root_reg.a.x);
            tsl_pkg::REG_ROOT_A_Y: prdata = tsl_pkg::DATA_W'(root_reg.a.y);
            tsl_pkg::REG_ROOT_B_X: prdata = tsl_pkg::DATA_W'(root_reg.b.x);
            tsl_pkg::REG_ROOT_B_Y: prdata = tsl_pkg::DATA_W'(root_reg.b.y);
            tsl_pkg::REG_ROOT_C_X: prdata = tsl_pkg::DATA_W'(root_reg.c.x);
            tsl_pkg::REG_ROOT_C_Y: prdata = tsl_pkg::DATA_W'(root_reg.c.y);
            tsl_pkg::REG_LEVELS:   prdata = tsl_pkg::DATA_W'(levels_reg);
            default:               prdata = '0;
        endcase
    end

    assign lv_eff = (levels_reg > tsl_pkg::LEVEL_W'(NC)) ? tsl_pkg::LEVEL_W'(NC) : levels_reg;

    tsl_map u_map (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .bary_u    (s_tdata[WW-1:0]),
        .bary_v    (s_tdata[2*WW-1:WW]),
        .bary_w    (s_tdata[3*WW-1:2*WW]),
        .root      (root_reg),
        .out_valid (chain_valid[0]),
        .out_ready (chain_ready[0]),
        .out_item  (chain_item[0])
    );

    for (genvar gi = 0; gi < NC; gi++) begin : g_cell
        assign lvl_active[gi] = (tsl_pkg::LEVEL_W'(gi) < lv_eff);

        tsl_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .lvl_active (lvl_active[gi]),
            .in_valid   (chain_valid[gi]),
            .in_ready   (chain_ready[gi]),
            .in_item    (chain_item[gi]),
            .out_valid  (chain_valid[gi+1]),
            .out_ready  (chain_ready[gi+1]),
            .out_item   (chain_item[gi+1])
        );
    end

    assign res             = chain_item[NC];
    assign m_tvalid        = chain_valid[NC];
    assign chain_ready[NC] = m_tready;
    assign m_tdata = {res.vtx.c.y, res.vtx.c.x, res.vtx.b.y, res.vtx.b.x,
                      res.vtx.a.y, res.vtx.a.x, res.p.y, res.p.x, res.path};

`ifndef SYNTHESIS
    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid || m_tready) |-> s_tready)
        else $error("input stalled while result side free");

    a_levels_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_wr && cfg_idx == tsl_pkg::REG_LEVELS)
            |=> levels_reg == $past(pwdata[tsl_pkg::LEVEL_W-1:0]))
        else $error("levels register write lost");

    a_root_ax_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_wr && cfg_idx == tsl_pkg::REG_ROOT_A_X)
            |=> root_reg.a.x == $past(pwdata[CW-1:0]))
        else $error("root a x write lost");
`endif

endmodule

FILE: test/triangle_subdivision_locator_top_tb.sv
`timescale 1ns / 100ps

module triangle_subdivision_locator_top_tb;

    typedef struct packed {
        logic [tsl_pkg::WEIGHT_W-1:0] w;
        logic [tsl_pkg::WEIGHT_W-1:0] v;
        logic [tsl_pkg::WEIGHT_W-1:0] u;
    } bary_t;

    typedef struct packed {
        tsl_pkg::coord_t            cy;
        tsl_pkg::coord_t            cx;
        tsl_pkg::coord_t            by;
        tsl_pkg::coord_t            bx;
        tsl_pkg::coord_t            ay;
        tsl_pkg::coord_t            ax;
        tsl_pkg::coord_t            py;
        tsl_pkg::coord_t            px;
        logic [tsl_pkg::PATH_W-1:0] path;
    } cell_result_t;

    logic                           aclk;
    logic                           aresetn;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [tsl_pkg::ADDR_W-1:0]     paddr;
    logic [tsl_pkg::DATA_W-1:0]     pwdata;
    logic [tsl_pkg::DATA_W-1:0]     prdata;
    logic                           pready;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [tsl_pkg::IN_DATA_W-1:0]  s_tdata;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [tsl_pkg::OUT_DATA_W-1:0] m_tdata;

    bary_t          pending_q[$];
    cell_result_t   cell_expect_q[$];
    logic [tsl_pkg::COORD_W-1:0] root_reg [6];
    logic [tsl_pkg::LEVEL_W-1:0] levels_reg;
    int             send_idle_pct;
    int             recv_stall_pct;
    int             errors;
    logic           in_taken;

    triangle_subdivision_locator_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #3_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic longint clamp_coord(longint val);
        if (val > 64'sd8388607) return 64'sd8388607;
        if (val < -64'sd8388608) return -64'sd8388608;
        return val;
    endfunction

    // strictly same side of line o->d for points p and r
    function automatic bit on_side(longint px, longint py, longint ox, longint oy,
                                   longint dx, longint dy, longint rx, longint ry);
        longint vx, vy, c1, c2;
        vx = dx - ox;
        vy = dy - oy;
        c1 = (px - ox) * vy - (py - oy) * vx;
        c2 = (rx - ox) * vy - (ry - oy) * vx;
        return (c1 > 0 && c2 > 0) || (c1 < 0 && c2 < 0);
    endfunction

    function automatic cell_result_t locate_cell(bary_t b);
        longint ax, ay, bx, by, cx, cy, px, py;
        longint ma_x, ma_y, mb_x, mb_y, mc_x, mc_y;
        int lv;
        logic [1:0] child;
        logic [tsl_pkg::PATH_W-1:0] path;
        cell_result_t r;
        ax = longint'($signed(root_reg[tsl_pkg::REG_ROOT_A_X]));
        ay = longint'($signed(root_reg[tsl_pkg::REG_ROOT_A_Y]));
        bx = longint'($signed(root_reg[tsl_pkg::REG_ROOT_B_X]));
        by = longint'($signed(root_reg[tsl_pkg::REG_ROOT_B_Y]));
        cx = longint'($signed(root_reg[tsl_pkg::REG_ROOT_C_X]));
        cy = longint'($signed(root_reg[tsl_pkg::REG_ROOT_C_Y]));
        lv = (levels_reg > tsl_pkg::MAX_LEVELS) ? tsl_pkg::MAX_LEVELS : int'(levels_reg);
        px = clamp_coord((ax * longint'(b.u) + bx * longint'(b.v) + cx * longint'(b.w))
                         >>> tsl_pkg::WEIGHT_SHIFT);
        py = clamp_coord((ay * longint'(b.u) + by * longint'(b.v) + cy * longint'(b.w))
                         >>> tsl_pkg::WEIGHT_SHIFT);
        path = '0;
        for (int i = 0; i < lv; i++) begin
            ma_x = (bx + cx) >>> 1;
            ma_y = (by + cy) >>> 1;
            mb_x = (ax + cx) >>> 1;
            mb_y = (ay + cy) >>> 1;
            mc_x = (ax + bx) >>> 1;
            mc_y = (ay + by) >>> 1;
            if (on_side(px, py, mc_x, mc_y, mb_x, mb_y, ax, ay)) begin
                child = tsl_pkg::CHILD_A;
                bx = mb_x; by = mb_y; cx = mc_x; cy = mc_y;
            end else if (on_side(px, py, mc_x, mc_y, ma_x, ma_y, bx, by)) begin
                child = tsl_pkg::CHILD_B;
                ax = mc_x; ay = mc_y; cx = ma_x; cy = ma_y;
            end else if (on_side(px, py, mb_x, mb_y, ma_x, ma_y, cx, cy)) begin
                child = tsl_pkg::CHILD_C;
                ax = mb_x; ay = mb_y; bx = ma_x; by = ma_y;
            end else begin
                child = tsl_pkg::CHILD_MID;
                ax = mb_x; ay = mb_y; bx = ma_x; by = ma_y; cx = mc_x; cy = mc_y;
            end
            path = {path[tsl_pkg::PATH_W-3:0], child};
        end
        r.path = path;
        r.px = tsl_pkg::coord_t'(px);
        r.py = tsl_pkg::coord_t'(py);
        r.ax = tsl_pkg::coord_t'(ax);
        r.ay = tsl_pkg::coord_t'(ay);
        r.bx = tsl_pkg::coord_t'(bx);
        r.by = tsl_pkg::coord_t'(by);
        r.cx = tsl_pkg::coord_t'(cx);
        r.cy = tsl_pkg::coord_t'(cy);
        return r;
    endfunction

    function automatic void check_cell(cell_result_t want, cell_result_t got);
        string names [9] = '{"cell_path", "point_x", "point_y", "leaf_a_x", "leaf_a_y",
                             "leaf_b_x", "leaf_b_y", "leaf_c_x", "leaf_c_y"};
        logic [31:0] w;
        logic [31:0] g;
        for (int i = 0; i < 9; i++) begin
            if (i == 0) begin
                w = want.path;
                g = got.path;
            end else begin
                w = 32'(want[tsl_pkg::PATH_W + tsl_pkg::COORD_W * (i - 1) +: tsl_pkg::COORD_W]);
                g = 32'(got[tsl_pkg::PATH_W + tsl_pkg::COORD_W * (i - 1) +: tsl_pkg::COORD_W]);
            end
            if (w !== g) begin
                errors++;
                if (errors <= 10)
                    $display("%s mismatch: expected %h, got %h", names[i], w, g);
            end
        end
    endfunction

    function automatic bary_t mk_bary(int u, int v, int w);
        bary_t b;
        b.u = u[tsl_pkg::WEIGHT_W-1:0];
        b.v = v[tsl_pkg::WEIGHT_W-1:0];
        b.w = w[tsl_pkg::WEIGHT_W-1:0];
        return b;
    endfunction

    function automatic void add_item(bary_t b);
        pending_q.insert(pending_q.size(), b);
    endfunction

    function automatic bary_t next_bary();
        int u, v, w, rot;
        if ($urandom_range(3) != 0) begin
            u = $urandom_range(65536);
            v = $urandom_range(65536 - u);
            w = 65536 - u - v;
            rot = $urandom_range(2);
            if (rot == 1) return mk_bary(v, w, u);
            if (rot == 2) return mk_bary(w, u, v);
            return mk_bary(u, v, w);
        end
        return mk_bary($urandom_range(131071), $urandom_range(131071), $urandom_range(131071));
    endfunction

    function automatic int rand_coord();
        if ($urandom_range(1) == 0) return $urandom_range(65535) - 32768;
        return int'($signed(24'($urandom)));
    endfunction

    // driver
    always @(negedge aclk) begin
        if (aresetn && (!s_tvalid || in_taken)) begin
            if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata  <= tsl_pkg::IN_DATA_W'(pending_q.pop_front());
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        m_tready <= aresetn && ($urandom_range(99) >= recv_stall_pct);
    end

    // monitor
    always @(posedge aclk) begin
        in_taken <= s_tvalid && s_tready;
        if (aresetn) begin
            if (s_tvalid && s_tready)
                cell_expect_q.insert(cell_expect_q.size(),
                    locate_cell(bary_t'(s_tdata[3*tsl_pkg::WEIGHT_W-1:0])));
            if (m_tvalid && m_tready) begin
                if (cell_expect_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result %h", m_tdata);
                end else begin
                    check_cell(cell_expect_q.pop_front(), cell_result_t'(m_tdata));
                end
            end
        end
    end

    task automatic reg_write(logic [2:0] idx, logic [tsl_pkg::DATA_W-1:0] val);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == tsl_pkg::REG_LEVELS)
            levels_reg = val[tsl_pkg::LEVEL_W-1:0];
        else
            root_reg[idx] = val[tsl_pkg::COORD_W-1:0];
    endtask

    task automatic load_root(int ax, int ay, int bx, int by, int cx, int cy, int lv);
        reg_write(tsl_pkg::REG_ROOT_A_X, ax & 32'hFFFFFF);
        reg_write(tsl_pkg::REG_ROOT_A_Y, ay & 32'hFFFFFF);
        reg_write(tsl_pkg::REG_ROOT_B_X, bx & 32'hFFFFFF);
        reg_write(tsl_pkg::REG_ROOT_B_Y, by & 32'hFFFFFF);
        reg_write(tsl_pkg::REG_ROOT_C_X, cx & 32'hFFFFFF);
        reg_write(tsl_pkg::REG_ROOT_C_Y, cy & 32'hFFFFFF);
        reg_write(tsl_pkg::REG_LEVELS, lv & 32'h1F);
    endtask

    task automatic settle();
        while (pending_q.size() != 0 || s_tvalid || cell_expect_q.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic push_directed();
        // vertices, empty and overfull weights
        add_item(mk_bary(65536, 0, 0));
        add_item(mk_bary(0, 65536, 0));
        add_item(mk_bary(0, 0, 65536));
        add_item(mk_bary(0, 0, 0));
        add_item(mk_bary(131071, 131071, 131071));
        add_item(mk_bary(131071, 0, 0));
        add_item(mk_bary(0, 131071, 65536));
        // points on the midpoint lines
        add_item(mk_bary(32768, 32768, 0));
        add_item(mk_bary(0, 32768, 32768));
        add_item(mk_bary(32768, 0, 32768));
        add_item(mk_bary(16384, 16384, 32768));
        // points near each child
        add_item(mk_bary(21845, 21845, 21846));
        add_item(mk_bary(1, 1, 1));
        add_item(mk_bary(65535, 1, 0));
        add_item(mk_bary(43690, 10923, 10923));
        add_item(mk_bary(10923, 43690, 10923));
        add_item(mk_bary(10923, 10923, 43690));
        add_item(mk_bary(21845, 21845, 21845));
    endtask

    initial begin
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        m_tready       = 1'b0;
        aresetn        = 1'b0;
        in_taken       = 1'b0;
        errors         = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        root_reg[tsl_pkg::REG_ROOT_A_X] = '0;
        root_reg[tsl_pkg::REG_ROOT_A_Y] = '0;
        root_reg[tsl_pkg::REG_ROOT_B_X] = 24'd4096;
        root_reg[tsl_pkg::REG_ROOT_B_Y] = '0;
        root_reg[tsl_pkg::REG_ROOT_C_X] = '0;
        root_reg[tsl_pkg::REG_ROOT_C_Y] = 24'd4096;
        levels_reg = 5'd8;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;

        for (int phase = 0; phase < 10; phase++) begin
            settle();
            case (phase)
                0: ;
                1: load_root(-8388608, -8388608, 8388607, -8388608, -8388608, 8388607, 16);
                2: load_root(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                             rand_coord(), rand_coord(), 0);
                3: load_root(1000, -2000, 1000, -2000, 1000, -2000, 31);
                4: load_root(0, 0, 4096, 4096, 8192, 8192, 5);
                5: load_root(-4096, 4096, 8388607, 8388607, -8388608, 0, 1);
                default: load_root(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                                   rand_coord(), rand_coord(), $urandom_range(31));
            endcase
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
                default: begin send_idle_pct = 25; recv_stall_pct = 25; end
            endcase
            if (phase < 2)
                push_directed();
            for (int i = 0; i < 150; i++)
                add_item(next_bary());
        end

        settle();
        repeat (40) @(posedge aclk);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
